// ===== rtl/rlps_pkg.sv =====
`timescale 1ns / 1ps

package rlps_pkg;

    localparam int MAX_STEPS = 8;
    localparam int IDX_W     = $clog2(MAX_STEPS);
    localparam int CNT_W     = $clog2(MAX_STEPS + 1);
    localparam int PTR1_W    = IDX_W + 1;
    // step memory holds two banks of MAX_STEPS entries
    localparam int ADDR_W    = IDX_W + 1;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_START = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef struct packed {
        logic        on;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [31:0] dur;
    } t_step;

    typedef struct packed {
        logic       lit;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_led;

    typedef struct packed {
        t_led led;
        logic status;
    } t_result;

    typedef struct packed {
        t_action     action;
        logic [63:0] now_ms;
        logic [2:0]  step_index;
        t_step       step;
        logic [3:0]  step_count;
        logic [31:0] cycle_count;
    } t_item;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_step             data;
    } t_ram_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_ram_rd;

    function automatic t_led led_of(input t_step s);
        t_led l;
        l = '0;
        if (s.on) begin
            l.lit   = 1'b1;
            l.red   = s.red;
            l.green = s.green;
            l.blue  = s.blue;
        end
        return l;
    endfunction

endpackage

// ===== rtl/rgb_led_pattern_sequencer_unit.sv =====
`timescale 1ns / 1ps

// rgb led pattern sequencer
// input stream: tuser carries the action (tick, write step, start request), tdata the
// time, step fields and start fields. every accepted beat gives exactly one output beat
// with the led drive after that item and a status flag (set for a rejected start).
// results are registered; one item is taken per cycle while the output queue has room.
// the step memory does not limit the rate: each tick issues its registered read for the
// step that the following tick may move to, so the timer compare never waits on it.
// staging and playing copies share one two-bank step memory; a start tick copies the
// per-entry staging bank marks to the playing marks instead of copying the table.
// results sit in a two-beat output queue; input tready drops only when both are held,
// so a stalled receiver is absorbed without losing or repeating a beat.
// reset (synchronous, active low) clears the pending request, the timer and pointer
// state and turns the led off; the step tables hold nothing until written, and no
// clearing pass is run, so items are accepted from the first cycle after reset.
module rgb_led_pattern_sequencer_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // now_ms, step_index, step_on, red, green, blue, step length, step_count, cycle_count
    input  logic [159:0] i_s_axis_tdata,
    // action
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // led_lit, drive_red, drive_green, drive_blue, zero fill
    output logic [31:0]  o_m_axis_tdata,
    // status
    output logic [0:0]   o_m_axis_tuser
);

    rlps_pkg::t_item   item;
    rlps_pkg::t_ram_wr ram_wr;
    rlps_pkg::t_ram_rd ram_rd;
    rlps_pkg::t_step   rd_data;
    rlps_pkg::t_result result;
    rlps_pkg::t_result out_data;
    logic              accept;
    logic              full;

    always_comb begin
        item.action      = rlps_pkg::t_action'(i_s_axis_tuser);
        item.now_ms      = i_s_axis_tdata[63:0];
        item.step_index  = i_s_axis_tdata[66:64];
        item.step.on     = i_s_axis_tdata[67];
        item.step.red    = i_s_axis_tdata[75:68];
        item.step.green  = i_s_axis_tdata[83:76];
        item.step.blue   = i_s_axis_tdata[91:84];
        item.step.dur    = i_s_axis_tdata[123:92];
        item.step_count  = i_s_axis_tdata[127:124];
        item.cycle_count = i_s_axis_tdata[159:128];
    end

    assign o_s_axis_tready = ~full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    rlps_step_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd      (ram_rd),
        .o_rd_data (rd_data)
    );

    rlps_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (item),
        .i_rd_data (rd_data),
        .o_wr      (ram_wr),
        .o_rd      (ram_rd),
        .o_result  (result)
    );

    rlps_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (result),
        .o_full  (full),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (out_data)
    );

    assign o_m_axis_tdata = {7'd0, out_data.led.blue, out_data.led.green,
                             out_data.led.red, out_data.led.lit};
    assign o_m_axis_tuser = out_data.status;

endmodule

// ===== rtl/rlps_step_ram.sv =====
`timescale 1ns / 1ps

module rlps_step_ram (
    input  logic              i_clk,
    input  rlps_pkg::t_ram_wr i_wr,
    input  rlps_pkg::t_ram_rd i_rd,
    output rlps_pkg::t_step   o_rd_data
);

    rlps_pkg::t_step r_mem [2*rlps_pkg::MAX_STEPS];
    rlps_pkg::t_step r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/rlps_core.sv =====
`timescale 1ns / 1ps

module rlps_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  rlps_pkg::t_item   i_item,
    input  rlps_pkg::t_step   i_rd_data,
    output rlps_pkg::t_ram_wr o_wr,
    output rlps_pkg::t_ram_rd o_rd,
    output rlps_pkg::t_result o_result
);

    localparam int IW = rlps_pkg::IDX_W;
    localparam int CW = rlps_pkg::CNT_W;
    localparam int PW = rlps_pkg::PTR1_W;
    localparam int MS = rlps_pkg::MAX_STEPS;

    logic [CW-1:0]   r_pend_steps, n_pend_steps;
    logic [31:0]     r_pend_cycles, n_pend_cycles;
    logic            r_req, n_req;
    logic [IW-1:0]   r_ptr, n_ptr;
    logic [31:0]     r_cycles, n_cycles;
    logic [CW-1:0]   r_steps, n_steps;
    logic [63:0]     r_start, n_start;
    logic [31:0]     r_len, n_len;
    rlps_pkg::t_led  r_led, n_led;
    // per entry: bank holding the latest staging copy, and bank being played
    logic [MS-1:0]   r_stg_bank, n_stg_bank;
    logic [MS-1:0]   r_act_bank, n_act_bank;
    // staging entries 0 and 1 kept aside, a start tick may need both at once
    rlps_pkg::t_step r_sh0, n_sh0;
    rlps_pkg::t_step r_sh1, n_sh1;

    logic            is_tick;
    logic            swap;
    logic [IW-1:0]   w_idx;
    logic            w_idx_ok;
    logic            start_ok;
    logic            w_bank;
    logic            status;

    logic [IW-1:0]   b_ptr;
    logic [31:0]     b_cyc;
    logic [CW-1:0]   b_steps;
    logic [63:0]     b_start;
    logic [31:0]     b_len;
    rlps_pkg::t_led  b_led;
    rlps_pkg::t_step nx_entry;
    logic [63:0]     diff;
    logic            expired;
    logic            running;
    logic [PW-1:0]   p1;
    logic [PW-1:0]   q1;
    logic [IW-1:0]   nx_idx;

    assign is_tick  = i_accept && (i_item.action == rlps_pkg::ACT_TICK);
    assign swap     = is_tick && r_req;
    assign w_idx    = IW'(i_item.step_index);
    assign w_idx_ok = 32'(i_item.step_index) < 32'(MS);
    assign start_ok = (i_item.step_count != 4'd0) && (32'(i_item.step_count) <= 32'(MS));
    // never overwrite the copy that is being played
    assign w_bank   = (r_stg_bank[w_idx] == r_act_bank[w_idx]) ? ~r_stg_bank[w_idx]
                                                                : r_stg_bank[w_idx];

    // state the tick starts from: a pending request first restarts at step 0
    always_comb begin
        if (swap) begin
            b_ptr    = '0;
            b_cyc    = r_pend_cycles;
            b_steps  = r_pend_steps;
            b_start  = i_item.now_ms;
            b_len    = r_sh0.dur;
            b_led    = rlps_pkg::led_of(r_sh0);
            nx_entry = (r_pend_steps == CW'(1)) ? r_sh0 : r_sh1;
        end else begin
            b_ptr    = r_ptr;
            b_cyc    = r_cycles;
            b_steps  = r_steps;
            b_start  = r_start;
            b_len    = r_len;
            b_led    = r_led;
            nx_entry = i_rd_data;
        end
    end

    assign diff    = i_item.now_ms - b_start;
    assign expired = diff >= {32'd0, b_len};
    assign running = (b_cyc != 32'd0) && (b_steps != '0);
    assign p1      = {1'b0, b_ptr} + PW'(1);

    always_comb begin
        n_pend_steps  = r_pend_steps;
        n_pend_cycles = r_pend_cycles;
        n_req         = r_req;
        n_ptr         = r_ptr;
        n_cycles      = r_cycles;
        n_steps       = r_steps;
        n_start       = r_start;
        n_len         = r_len;
        n_led         = r_led;
        n_stg_bank    = r_stg_bank;
        n_act_bank    = r_act_bank;
        n_sh0         = r_sh0;
        n_sh1         = r_sh1;
        status        = 1'b0;
        o_wr          = '0;
        if (i_accept) begin
            unique case (i_item.action)
                rlps_pkg::ACT_TICK: begin
                    if (swap) begin
                        n_req      = 1'b0;
                        n_act_bank = r_stg_bank;
                    end
                    n_ptr    = b_ptr;
                    n_cycles = b_cyc;
                    n_steps  = b_steps;
                    n_start  = b_start;
                    n_len    = b_len;
                    n_led    = b_led;
                    if (running && expired) begin
                        if (p1 >= PW'(b_steps)) begin
                            n_ptr = '0;
                            if (!b_cyc[31]) begin
                                n_cycles = b_cyc - 32'd1;
                            end
                            if (n_cycles == 32'd0) begin
                                n_led = '0;
                            end else begin
                                n_start = i_item.now_ms;
                                n_len   = nx_entry.dur;
                                n_led   = rlps_pkg::led_of(nx_entry);
                            end
                        end else begin
                            n_ptr   = p1[IW-1:0];
                            n_start = i_item.now_ms;
                            n_len   = nx_entry.dur;
                            n_led   = rlps_pkg::led_of(nx_entry);
                        end
                    end
                end
                rlps_pkg::ACT_WRITE: begin
                    if (w_idx_ok) begin
                        o_wr.en            = 1'b1;
                        o_wr.addr          = {w_bank, w_idx};
                        o_wr.data          = i_item.step;
                        n_stg_bank[w_idx]  = w_bank;
                        if (i_item.step_index == 3'd0) begin
                            n_sh0 = i_item.step;
                        end
                        if (i_item.step_index == 3'd1) begin
                            n_sh1 = i_item.step;
                        end
                    end
                end
                rlps_pkg::ACT_START: begin
                    if (start_ok) begin
                        n_pend_steps  = CW'(i_item.step_count);
                        n_pend_cycles = i_item.cycle_count;
                        n_req         = 1'b1;
                    end else begin
                        status = 1'b1;
                    end
                end
                rlps_pkg::ACT_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // prefetch the entry the following tick would move to
    assign q1     = {1'b0, n_ptr} + PW'(1);
    assign nx_idx = (q1 >= PW'(n_steps)) ? '0 : q1[IW-1:0];

    always_comb begin
        o_rd.en   = is_tick;
        o_rd.addr = {n_act_bank[nx_idx], nx_idx};
    end

    assign o_result.led    = n_led;
    assign o_result.status = status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_steps  <= '0;
            r_pend_cycles <= '0;
            r_req         <= 1'b0;
            r_ptr         <= '0;
            r_cycles      <= '0;
            r_steps       <= '0;
            r_start       <= '0;
            r_len         <= '0;
            r_led         <= '0;
            r_stg_bank    <= '0;
            r_act_bank    <= '0;
        end else begin
            r_pend_steps  <= n_pend_steps;
            r_pend_cycles <= n_pend_cycles;
            r_req         <= n_req;
            r_ptr         <= n_ptr;
            r_cycles      <= n_cycles;
            r_steps       <= n_steps;
            r_start       <= n_start;
            r_len         <= n_len;
            r_led         <= n_led;
            r_stg_bank    <= n_stg_bank;
            r_act_bank    <= n_act_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh0 <= n_sh0;
        r_sh1 <= n_sh1;
    end

endmodule

// ===== rtl/rlps_out_buf.sv =====
`timescale 1ns / 1ps

module rlps_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rlps_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output rlps_pkg::t_result o_data
);

    rlps_pkg::t_result r_buf [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_buf[r_rd];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr  = i_push ? ~r_wr : r_wr;
        n_rd  = pop ? ~r_rd : r_rd;
        n_cnt = r_cnt + 2'(i_push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

endmodule
